// File: src/bsfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types and constants for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_VERDICT = 2'd1;
  localparam kind_t KIND_ABANDON = 2'd2;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_START_BYTE  = 3'd0;
  localparam cfg_idx_t CFG_END_BYTE    = 3'd1;
  localparam cfg_idx_t CFG_ESCAPE_BYTE = 3'd2;
  localparam cfg_idx_t CFG_ESCAPE_MASK = 3'd3;
  localparam cfg_idx_t CFG_STALE_LIMIT = 3'd4;

  localparam logic [7:0]  RST_START_BYTE  = 8'd126;
  localparam logic [7:0]  RST_END_BYTE    = 8'd127;
  localparam logic [7:0]  RST_ESCAPE_BYTE = 8'd125;
  localparam logic [7:0]  RST_ESCAPE_MASK = 8'd32;
  localparam logic [15:0] RST_STALE_LIMIT = 16'd1000;

  localparam logic [15:0] IDLE_SAT = 16'hffff;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

endpackage
`default_nettype wire

// File: src/byte_stuffed_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_core
// Byte-stuffed frame receiver with a trailing Fletcher-16 check.
// ----------------------------------------------------------------------------
// Takes one request (received byte or idle tick) per clock. Each request is
// decoded combinationally against the frame state and any result lands in a
// single output register, so throughput is one request per cycle unless
// stalled. The input stalls only while that output register holds a
// result that the receiver has not taken yet. Payload bytes leave through a
// two-byte delay so the last two bytes of a frame are held back as the
// little-endian check value (Fletcher-16 style, sums mod 256), compared at
// the end byte. A frame is abandoned after stale_limit idle ticks or when a
// byte arrives once MAX_FRAME_BYTES raw bytes have been seen. Configuration
// writes are always ready and should only be issued while the block is idle.
module byte_stuffed_frame_receiver_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic                       in_cmd,
  input  wire logic [7:0]                 in_rx_byte,
  // result channel
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      bsfr_pkg::kind_t            out_kind,
  output      logic [7:0]                 out_data_byte,
  output      logic                       out_checksum_ok,
  output      logic [8:0]                 out_payload_length,
  // configuration
  input  wire logic                       cfg_valid,
  output      logic                       cfg_ready,
  input  wire bsfr_pkg::cfg_idx_t         cfg_index,
  input  wire logic [15:0]                cfg_wdata
);

  localparam int RAW_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CW    = (RAW_W > 9) ? RAW_W : 9;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

  // configuration registers
  logic [7:0]  start_byte_r, end_byte_r, escape_byte_r, escape_mask_r;
  logic [15:0] stale_limit_r;

  // frame state
  logic          in_frame_r,   in_frame_nxt;
  logic          esc_pend_r,   esc_pend_nxt;
  logic [7:0]    held0_r,      held0_nxt;
  logic [7:0]    held1_r,      held1_nxt;
  logic [1:0]    held_cnt_r,   held_cnt_nxt;
  logic [7:0]    sum_lo_r,     sum_lo_nxt;
  logic [7:0]    sum_hi_r,     sum_hi_nxt;
  logic [CW-1:0] raw_cnt_r,    raw_cnt_nxt;
  logic [CW-1:0] pay_cnt_r,    pay_cnt_nxt;
  logic [15:0]   idle_r,       idle_nxt;

  // output register
  logic            out_valid_r,  out_valid_nxt;
  bsfr_pkg::kind_t out_kind_r,   out_kind_nxt;
  logic [7:0]      out_data_r,   out_data_nxt;
  logic            out_ok_r,     out_ok_nxt;
  logic [8:0]      out_len_r,    out_len_nxt;

  logic          accept;
  logic          emit;
  logic          push;
  logic [7:0]    value;
  logic [15:0]   idle_inc;
  logic [7:0]    sum_lo_add;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_pend_nxt = esc_pend_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    sum_lo_nxt   = sum_lo_r;
    sum_hi_nxt   = sum_hi_r;
    raw_cnt_nxt  = raw_cnt_r;
    pay_cnt_nxt  = pay_cnt_r;
    idle_nxt     = idle_r;
    emit         = 1'b0;
    push         = 1'b0;
    value        = in_rx_byte;
    out_kind_nxt = bsfr_pkg::KIND_PAYLOAD;
    out_data_nxt = 8'd0;
    out_ok_nxt   = 1'b0;
    out_len_nxt  = pay_cnt_r[8:0];
    idle_inc     = (idle_r != bsfr_pkg::IDLE_SAT) ? idle_r + 16'd1 : idle_r;
    sum_lo_add   = sum_lo_r + held0_r;

    if (!in_frame_r) begin
      // hunting: only the start byte matters
      if (in_cmd == bsfr_pkg::CMD_BYTE && in_rx_byte == start_byte_r) begin
        in_frame_nxt = 1'b1;
        esc_pend_nxt = 1'b0;
        held0_nxt    = 8'd0;
        held1_nxt    = 8'd0;
        held_cnt_nxt = 2'd0;
        sum_lo_nxt   = 8'd0;
        sum_hi_nxt   = 8'd0;
        raw_cnt_nxt  = CW'(1);
        pay_cnt_nxt  = '0;
        idle_nxt     = 16'd0;
      end
    end else if (in_cmd == bsfr_pkg::CMD_TICK) begin
      idle_nxt = idle_inc;
      if (idle_inc >= stale_limit_r) begin
        emit         = 1'b1;
        out_kind_nxt = bsfr_pkg::KIND_ABANDON;
        in_frame_nxt = 1'b0;
      end
    end else begin
      idle_nxt = 16'd0;
      if (raw_cnt_r >= MAX_CNT) begin
        emit         = 1'b1;
        out_kind_nxt = bsfr_pkg::KIND_ABANDON;
        in_frame_nxt = 1'b0;
      end else begin
        raw_cnt_nxt = raw_cnt_r + CW'(1);
        if (in_rx_byte == end_byte_r) begin
          // end byte wins over a pending escape
          emit         = 1'b1;
          out_kind_nxt = bsfr_pkg::KIND_VERDICT;
          out_ok_nxt   = (held_cnt_r == 2'd2) && (held0_r == sum_lo_r) &&
                         (held1_r == sum_hi_r);
          in_frame_nxt = 1'b0;
        end else if (esc_pend_r) begin
          value        = in_rx_byte ^ escape_mask_r;
          esc_pend_nxt = 1'b0;
          push         = 1'b1;
        end else if (in_rx_byte == escape_byte_r) begin
          esc_pend_nxt = 1'b1;
        end else begin
          push = 1'b1;
        end
      end
    end

    if (push) begin
      if (held_cnt_r < 2'd2) begin
        if (held_cnt_r[0]) held1_nxt = value;
        else               held0_nxt = value;
        held_cnt_nxt = held_cnt_r + 2'd1;
      end else begin
        // oldest byte leaves the delay line and feeds the sum
        held0_nxt    = held1_r;
        held1_nxt    = value;
        sum_lo_nxt   = sum_lo_add;
        sum_hi_nxt   = sum_hi_r + sum_lo_add;
        pay_cnt_nxt  = pay_cnt_r + CW'(1);
        emit         = 1'b1;
        out_kind_nxt = bsfr_pkg::KIND_PAYLOAD;
        out_data_nxt = held0_r;
        out_len_nxt  = pay_cnt_nxt[8:0];
      end
    end

    // frame closed: back to the cleared hunting state
    if (emit && out_kind_nxt != bsfr_pkg::KIND_PAYLOAD) begin
      esc_pend_nxt = 1'b0;
      held0_nxt    = 8'd0;
      held1_nxt    = 8'd0;
      held_cnt_nxt = 2'd0;
      sum_lo_nxt   = 8'd0;
      sum_hi_nxt   = 8'd0;
      raw_cnt_nxt  = '0;
      pay_cnt_nxt  = '0;
      idle_nxt     = 16'd0;
    end
  end

  always_comb begin
    if (accept && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= bsfr_pkg::RST_START_BYTE;
      end_byte_r    <= bsfr_pkg::RST_END_BYTE;
      escape_byte_r <= bsfr_pkg::RST_ESCAPE_BYTE;
      escape_mask_r <= bsfr_pkg::RST_ESCAPE_MASK;
      stale_limit_r <= bsfr_pkg::RST_STALE_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsfr_pkg::CFG_START_BYTE:  start_byte_r  <= cfg_wdata[7:0];
        bsfr_pkg::CFG_END_BYTE:    end_byte_r    <= cfg_wdata[7:0];
        bsfr_pkg::CFG_ESCAPE_BYTE: escape_byte_r <= cfg_wdata[7:0];
        bsfr_pkg::CFG_ESCAPE_MASK: escape_mask_r <= cfg_wdata[7:0];
        bsfr_pkg::CFG_STALE_LIMIT: stale_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_pend_r  <= 1'b0;
      held0_r     <= 8'd0;
      held1_r     <= 8'd0;
      held_cnt_r  <= 2'd0;
      sum_lo_r    <= 8'd0;
      sum_hi_r    <= 8'd0;
      raw_cnt_r   <= '0;
      pay_cnt_r   <= '0;
      idle_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        in_frame_r <= in_frame_nxt;
        esc_pend_r <= esc_pend_nxt;
        held0_r    <= held0_nxt;
        held1_r    <= held1_nxt;
        held_cnt_r <= held_cnt_nxt;
        sum_lo_r   <= sum_lo_nxt;
        sum_hi_r   <= sum_hi_nxt;
        raw_cnt_r  <= raw_cnt_nxt;
        pay_cnt_r  <= pay_cnt_nxt;
        idle_r     <= idle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
      out_ok_r   <= out_ok_nxt;
      out_len_r  <= out_len_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_data_byte      = out_data_r;
  assign out_checksum_ok    = out_ok_r;
  assign out_payload_length = out_len_r;

endmodule
`default_nettype wire

// File: src/bsfr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module bsfr_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire bsfr_pkg::kind_t out_kind,
  input wire logic [7:0]      out_data_byte,
  input wire logic            out_checksum_ok,
  input wire logic [8:0]      out_payload_length
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_data_byte) &&
      $stable(out_checksum_ok) && $stable(out_payload_length))
    else $error("stalled result changed");

  // input only backs up behind a pending result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != bsfr_pkg::KIND_PAYLOAD |-> out_data_byte == 8'd0)
    else $error("data byte set on a non-payload result");

  a_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != bsfr_pkg::KIND_VERDICT |-> !out_checksum_ok)
    else $error("checksum flag set outside a verdict");

endmodule

bind byte_stuffed_frame_receiver_core bsfr_checker u_bsfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_data_byte      (out_data_byte),
  .out_checksum_ok    (out_checksum_ok),
  .out_payload_length (out_payload_length)
);
`default_nettype wire
